// ===== hdl/vam_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and codes for the vibration amplitude monitor
package vam_pkg;

    localparam int MAG_W = 17;
    localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;

    localparam int FRAME_LENGTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WARN_THRESHOLD = 3'd4;

    localparam logic [MAG_W-1:0] ALARM_THRESHOLD_RESET = 17'd3341;
    localparam logic [MAG_W-1:0] WARN_THRESHOLD_RESET = 17'd2506;

    localparam int LEVEL_W = 2;
    localparam logic [LEVEL_W-1:0] LEVEL_OK = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ALARM = 2'd2;

endpackage

// ===== hdl/vam_sqsum.sv =====
`timescale 1ns / 1ps
// bit-serial sum of squares of three signed axis differences
module vam_sqsum #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SAMPLE_BITS:0]       diff_x,
    input  logic [SAMPLE_BITS:0]       diff_y,
    input  logic [SAMPLE_BITS:0]       diff_z,
    output logic                       done,
    output logic [2*SAMPLE_BITS+3:0]   sum
);

    localparam int A_W = SAMPLE_BITS + 1;
    localparam int P_W = 2 * A_W;
    localparam int S_W = P_W + 2;
    localparam int CNT_W = $clog2(A_W);

    logic [A_W-1:0] diff_in [3];
    logic [A_W-1:0] abs_val [3];
    logic [A_W-1:0] mult_reg [3];
    logic [P_W-1:0] mcand_reg [3];
    logic [P_W-1:0] acc_reg [3];
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic sum_en_reg;
    logic done_reg;
    logic [S_W-1:0] sum_reg;

    assign diff_in[0] = diff_x;
    assign diff_in[1] = diff_y;
    assign diff_in[2] = diff_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_val[i] = diff_in[i][A_W-1] ? (~diff_in[i] + 1'b1) : diff_in[i];
        end
    end

    // one multiplier bit per cycle on each axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mult_reg[i] <= '0;
                mcand_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            sum_en_reg <= 1'b0;
            done_reg <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            sum_en_reg <= 1'b0;
            if (start)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mult_reg[i] <= abs_val[i];
                    mcand_reg[i] <= P_W'(abs_val[i]);
                    acc_reg[i] <= '0;
                end
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= acc_reg[i] + (mult_reg[i][0] ? mcand_reg[i] : '0);
                    mcand_reg[i] <= mcand_reg[i] << 1;
                    mult_reg[i] <= mult_reg[i] >> 1;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(A_W - 1))
                begin
                    busy_reg <= 1'b0;
                    sum_en_reg <= 1'b1;
                end
            end
            if (sum_en_reg)
            begin
                sum_reg <= S_W'(acc_reg[0]) + S_W'(acc_reg[1]) + S_W'(acc_reg[2]);
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign sum = sum_reg;

endmodule

// ===== hdl/vam_isqrt.sv =====
`timescale 1ns / 1ps
// digit-by-digit floor square root, one root bit per cycle
module vam_isqrt #(
    parameter int IN_W = 36
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [IN_W-1:0]      radicand,
    output logic                 done,
    output logic [IN_W/2-1:0]    root
);

    localparam int OUT_W = IN_W / 2;
    localparam int CNT_W = $clog2(OUT_W);

    logic [IN_W-1:0] rad_reg;
    logic [OUT_W-1:0] rem_reg;
    logic [OUT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    logic [OUT_W+1:0] rem_sh;
    logic [OUT_W+1:0] trial;
    logic [OUT_W+1:0] rem_diff;
    logic ge;

    assign rem_sh = {rem_reg, rad_reg[IN_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign ge = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg <= radicand;
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg <= rad_reg << 2;
                rem_reg <= ge ? rem_diff[OUT_W-1:0] : rem_sh[OUT_W-1:0];
                root_reg <= {root_reg[OUT_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/vibration_amplitude_monitor.sv =====
`timescale 1ns / 1ps
// top level: offset correction, magnitude, frame min/max and level report
//
// in channel: accel_x/y/z with in_valid/in_stall; a transfer happens when
// in_valid is high and in_stall is low. out channel: one result per sample
// with out_valid/out_stall. magnitude comes with every result; frame_done
// marks the last sample of each FRAME_LENGTH-sample frame and then carries
// frame_min, frame_max, peak_to_peak and level (zero otherwise).
// cfg port: cfg_we, cfg_index, cfg_data; the user must write these only
// while idle; the block itself does not enforce this. each sample passes
// through the bit-serial squaring and the square root unit, one sample at
// a time: in_stall stays high until its result is registered. the output
// register lets the next sample enter while a result waits; a stalled
// receiver holds the result and the block stops after the next sample is
// computed. reset loads default thresholds, zero offsets and starts a
// fresh frame.
module vibration_amplitude_monitor #(
    parameter int FRAME_LENGTH = vam_pkg::FRAME_LENGTH_DEF,
    parameter int SAMPLE_BITS = vam_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [SAMPLE_BITS-1:0]             accel_x,
    input  logic [SAMPLE_BITS-1:0]             accel_y,
    input  logic [SAMPLE_BITS-1:0]             accel_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vam_pkg::MAG_W-1:0]          magnitude,
    output logic                               frame_done,
    output logic [vam_pkg::MAG_W-1:0]          frame_min,
    output logic [vam_pkg::MAG_W-1:0]          frame_max,
    output logic [vam_pkg::MAG_W-1:0]          peak_to_peak,
    output logic [vam_pkg::LEVEL_W-1:0]        level,
    input  logic                               cfg_we,
    input  logic [vam_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [(SAMPLE_BITS > vam_pkg::MAG_W ? SAMPLE_BITS : vam_pkg::MAG_W)-1:0] cfg_data
);

    import vam_pkg::*;

    localparam int D_W = SAMPLE_BITS + 1;
    localparam int SUM_W = 2 * D_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int RX_W = ROOT_W + MAG_W;
    localparam int CNT_W = $clog2(FRAME_LENGTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [SAMPLE_BITS-1:0] off_x_reg;
    logic [SAMPLE_BITS-1:0] off_y_reg;
    logic [SAMPLE_BITS-1:0] off_z_reg;
    logic [MAG_W-1:0] alarm_reg;
    logic [MAG_W-1:0] warn_reg;

    logic [D_W-1:0] diff_x_reg;
    logic [D_W-1:0] diff_y_reg;
    logic [D_W-1:0] diff_z_reg;
    logic start_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [CNT_W-1:0] count_reg;
    logic [MAG_W-1:0] run_max_reg;
    logic [MAG_W-1:0] run_min_reg;

    logic out_valid_reg;
    logic [MAG_W-1:0] magnitude_reg;
    logic frame_done_reg;
    logic [MAG_W-1:0] frame_min_reg;
    logic [MAG_W-1:0] frame_max_reg;
    logic [MAG_W-1:0] p2p_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic sq_done;
    logic [SUM_W-1:0] sq_sum;
    logic rt_done;
    logic [ROOT_W-1:0] rt_root;
    logic [RX_W-1:0] root_ext;
    logic [MAG_W-1:0] root_sat;

    logic in_xfer;
    logic out_free;
    logic frame_last;
    logic [MAG_W-1:0] new_max;
    logic [MAG_W-1:0] new_min;
    logic [MAG_W-1:0] p2p;
    logic [LEVEL_W-1:0] level_val;

    vam_sqsum #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_sqsum (
        .clk(clk),
        .rst_n(rst_n),
        .start(start_reg),
        .diff_x(diff_x_reg),
        .diff_y(diff_y_reg),
        .diff_z(diff_z_reg),
        .done(sq_done),
        .sum(sq_sum)
    );

    vam_isqrt #(
        .IN_W(SUM_W)
    ) u_isqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(sq_done),
        .radicand(sq_sum),
        .done(rt_done),
        .root(rt_root)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // saturate roots that do not fit the magnitude field
    assign root_ext = RX_W'(rt_root);
    assign root_sat = (root_ext > RX_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

    assign frame_last = (count_reg == CNT_W'(FRAME_LENGTH - 1));
    assign new_max = (mag_reg > run_max_reg) ? mag_reg : run_max_reg;
    assign new_min = (mag_reg < run_min_reg) ? mag_reg : run_min_reg;
    assign p2p = new_max - new_min;

    always_comb
    begin
        if (p2p >= alarm_reg)
        begin
            level_val = LEVEL_ALARM;
        end
        else if (p2p >= warn_reg)
        begin
            level_val = LEVEL_WARN;
        end
        else
        begin
            level_val = LEVEL_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            alarm_reg <= ALARM_THRESHOLD_RESET;
            warn_reg <= WARN_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_OFFSET_Y: off_y_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_OFFSET_Z: off_z_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_ALARM_THRESHOLD: alarm_reg <= cfg_data[MAG_W-1:0];
                REG_WARN_THRESHOLD: warn_reg <= cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            diff_x_reg <= '0;
            diff_y_reg <= '0;
            diff_z_reg <= '0;
            start_reg <= 1'b0;
            mag_reg <= '0;
            count_reg <= '0;
            run_max_reg <= '0;
            run_min_reg <= MAG_MAX;
            out_valid_reg <= 1'b0;
            magnitude_reg <= '0;
            frame_done_reg <= 1'b0;
            frame_min_reg <= '0;
            frame_max_reg <= '0;
            p2p_reg <= '0;
            level_reg <= LEVEL_OK;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        diff_x_reg <= {accel_x[SAMPLE_BITS-1], accel_x}
                                    - {off_x_reg[SAMPLE_BITS-1], off_x_reg};
                        diff_y_reg <= {accel_y[SAMPLE_BITS-1], accel_y}
                                    - {off_y_reg[SAMPLE_BITS-1], off_y_reg};
                        diff_z_reg <= {accel_z[SAMPLE_BITS-1], accel_z}
                                    - {off_z_reg[SAMPLE_BITS-1], off_z_reg};
                        start_reg <= 1'b1;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (rt_done)
                    begin
                        mag_reg <= root_sat;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        magnitude_reg <= mag_reg;
                        if (frame_last)
                        begin
                            frame_done_reg <= 1'b1;
                            frame_min_reg <= new_min;
                            frame_max_reg <= new_max;
                            p2p_reg <= p2p;
                            level_reg <= level_val;
                            count_reg <= '0;
                            run_max_reg <= '0;
                            run_min_reg <= MAG_MAX;
                        end
                        else
                        begin
                            frame_done_reg <= 1'b0;
                            frame_min_reg <= '0;
                            frame_max_reg <= '0;
                            p2p_reg <= '0;
                            level_reg <= LEVEL_OK;
                            count_reg <= count_reg + 1'b1;
                            run_max_reg <= new_max;
                            run_min_reg <= new_min;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign frame_done = frame_done_reg;
    assign frame_min = frame_min_reg;
    assign frame_max = frame_max_reg;
    assign peak_to_peak = p2p_reg;
    assign level = level_reg;

    a_out_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished sample");

    a_p2p_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_done_reg) |->
            (frame_max_reg >= frame_min_reg) && (p2p_reg == frame_max_reg - frame_min_reg))
        else $error("frame summary inconsistent");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRAME_LENGTH - 1))
        else $error("sample count past frame end");

    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_CALC) && start_reg)
        else $error("accepted sample did not start computation");

endmodule
